/* rtl/cvg_pkg.sv */
// ----------------------------------------------------------------------------
// Circle vertex generator package
// Widths, register indexes and the elaboration-time sine/cosine table maths.
// ----------------------------------------------------------------------------
package cvg_pkg;

    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 12;
    localparam int VERTEX_W   = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int TABLE_POINTS_DEF  = 64;
    localparam int FRACTION_BITS_DEF = 14;

    localparam logic [RADIUS_W-1:0] SMALL_LIMIT_RESET = RADIUS_W'(20);

    localparam longint           Q30_ONE      = 64'sd1073741824;
    localparam longint unsigned  Q30_HALF_PI  = 64'd1686629713;
    localparam int               TAYLOR_TERMS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_LEFT   = 3'd0,
        CFG_VIEW_TOP    = 3'd1,
        CFG_VIEW_RIGHT  = 3'd2,
        CFG_VIEW_BOTTOM = 3'd3,
        CFG_SMALL_LIMIT = 3'd4
    } t_cfg_idx;

    // Request fields handed from the sequencer to the vertex pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       radius;
        logic                      reject;
        logic                      last;
    } t_issue;

    // Unsigned quotient by shift and subtract, used only while building the table.
    function automatic longint unsigned cvg_udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Sine (want_cos = 0) or cosine of Idx/Points of a turn, in Q30.
    function automatic longint cvg_trig_q30(int unsigned Idx, int unsigned Points,
                                            bit want_cos);
        longint unsigned phase;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned ts;
        longint unsigned tc;
        longint          ss;
        longint          cs;
        logic [1:0]      quad;
        longint          rs;
        longint          rc;
        ss = 0;
        cs = 0;
        phase = cvg_udiv(64'(Idx) << 32, 64'(Points));
        quad  = phase[31:30];
        a     = ((phase & 64'h3FFF_FFFF) * Q30_HALF_PI) >> 30;
        a2    = (a * a) >> 30;
        ts    = a;
        tc    = Q30_ONE;
        for (int k = 0; k < TAYLOR_TERMS; k++) begin
            if (k[0] == 1'b1) begin
                ss = ss - longint'(ts);
                cs = cs - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cs = cs + longint'(tc);
            end
            ts = cvg_udiv((ts * a2) >> 30, 64'((2 * k + 2) * (2 * k + 3)));
            tc = cvg_udiv((tc * a2) >> 30, 64'((2 * k + 1) * (2 * k + 2)));
        end
        if (ss < 0)       ss = 0;
        if (ss > Q30_ONE) ss = Q30_ONE;
        if (cs < 0)       cs = 0;
        if (cs > Q30_ONE) cs = Q30_ONE;
        case (quad)
            2'd0:    begin rs = ss;  rc = cs;  end
            2'd1:    begin rs = cs;  rc = -ss; end
            2'd2:    begin rs = -ss; rc = -cs; end
            default: begin rs = -cs; rc = ss;  end
        endcase
        return want_cos ? rc : rs;
    endfunction

    // Table entry: the Q30 value rounded by magnitude to FracBits, half away from zero.
    function automatic longint cvg_table_entry(int unsigned Idx, int unsigned Points,
                                               int unsigned FracBits, bit want_cos);
        longint          v;
        longint unsigned m;
        v = cvg_trig_q30(Idx, Points, want_cos);
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

endpackage

/* rtl/cvg_req_if.sv */
// ----------------------------------------------------------------------------
// Circle request channel
// Valid/ready channel carrying one circle: centre and radius.
// ----------------------------------------------------------------------------
interface cvg_req_if
    import cvg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       circle_radius;

    modport source (output valid, output center_x, output center_y,
                    output circle_radius, input ready);
    modport sink   (input valid, input center_x, input center_y,
                    input circle_radius, output ready);
endinterface

/* rtl/cvg_vtx_if.sv */
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying one polygon vertex or a rejection marker.
// ----------------------------------------------------------------------------
interface cvg_vtx_if
    import cvg_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VERTEX_W-1:0] vertex_x;
    logic signed [VERTEX_W-1:0] vertex_y;
    logic                       rejected;
    logic                       last_vertex;

    modport source (output valid, output vertex_x, output vertex_y,
                    output rejected, output last_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y,
                    input rejected, input last_vertex, output ready);
endinterface

/* rtl/cvg_vertex_pipe.sv */
// ----------------------------------------------------------------------------
// Vertex pipeline
// Three stages: table lookup, radius multiply, truncation and centre add.
// ----------------------------------------------------------------------------
module cvg_vertex_pipe
    import cvg_pkg::*;
#(
    parameter int TABLE_POINTS  = TABLE_POINTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_POINTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_issue_valid,
    output logic             o_issue_ready,
    input  logic [IDX_W-1:0] i_issue_idx,
    input  t_issue           i_issue,
    cvg_vtx_if.source        o_vtx
);

    localparam int MAG_W  = FRACTION_BITS + 1;
    localparam int PROD_W = RADIUS_W + MAG_W;

    // Constant sine/cosine table held as sign and magnitude.
    logic             w_sin_neg [TABLE_POINTS];
    logic             w_cos_neg [TABLE_POINTS];
    logic [MAG_W-1:0] w_sin_mag [TABLE_POINTS];
    logic [MAG_W-1:0] w_cos_mag [TABLE_POINTS];

    for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_tab
        localparam longint SIN_Q   = cvg_table_entry(g, TABLE_POINTS, FRACTION_BITS, 1'b0);
        localparam longint COS_Q   = cvg_table_entry(g, TABLE_POINTS, FRACTION_BITS, 1'b1);
        localparam longint SIN_ABS = (SIN_Q < 0) ? -SIN_Q : SIN_Q;
        localparam longint COS_ABS = (COS_Q < 0) ? -COS_Q : COS_Q;
        assign w_sin_neg[g] = (SIN_Q < 0);
        assign w_cos_neg[g] = (COS_Q < 0);
        assign w_sin_mag[g] = SIN_ABS[MAG_W-1:0];
        assign w_cos_mag[g] = COS_ABS[MAG_W-1:0];
    end

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    // Stage one: table lookup.
    t_issue           r_s1;
    logic             r_s1_sneg, r_s1_cneg;
    logic [MAG_W-1:0] r_s1_smag, r_s1_cmag;

    // Stage two: products.
    t_issue            r_s2;
    logic              r_s2_sneg, r_s2_cneg;
    logic [PROD_W-1:0] r_s2_px, r_s2_py;

    // Stage three: output register.
    logic signed [VERTEX_W-1:0] r_x, r_y;
    logic                       r_rej, r_last;

    logic [RADIUS_W-1:0]        w_mx, w_my;
    logic signed [RADIUS_W:0]   w_off_x, w_off_y;
    logic signed [VERTEX_W-1:0] n_x, n_y;

    assign w_en3         = !r_v3 || o_vtx.ready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign o_issue_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_issue_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1      <= i_issue;
            r_s1_sneg <= w_sin_neg[i_issue_idx];
            r_s1_cneg <= w_cos_neg[i_issue_idx];
            r_s1_smag <= w_sin_mag[i_issue_idx];
            r_s1_cmag <= w_cos_mag[i_issue_idx];
        end
        if (w_en2) begin
            r_s2      <= r_s1;
            r_s2_sneg <= r_s1_sneg;
            r_s2_cneg <= r_s1_cneg;
            r_s2_px   <= PROD_W'(r_s1.radius) * PROD_W'(r_s1_smag);
            r_s2_py   <= PROD_W'(r_s1.radius) * PROD_W'(r_s1_cmag);
        end
        if (w_en3) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_rej  <= r_s2.reject;
            r_last <= r_s2.last;
        end
    end

    // The entry magnitude never exceeds one, so the scaled offset fits the radius width.
    always_comb begin
        w_mx    = r_s2_px[FRACTION_BITS +: RADIUS_W];
        w_my    = r_s2_py[FRACTION_BITS +: RADIUS_W];
        w_off_x = r_s2_sneg ? -$signed({1'b0, w_mx}) : $signed({1'b0, w_mx});
        w_off_y = r_s2_cneg ? -$signed({1'b0, w_my}) : $signed({1'b0, w_my});
        if (r_s2.reject) begin
            n_x = '0;
            n_y = '0;
        end else begin
            n_x = VERTEX_W'(r_s2.cx) + VERTEX_W'(w_off_x);
            n_y = VERTEX_W'(r_s2.cy) + VERTEX_W'(w_off_y);
        end
    end

    assign o_vtx.valid       = r_v3;
    assign o_vtx.vertex_x    = r_x;
    assign o_vtx.vertex_y    = r_y;
    assign o_vtx.rejected    = r_rej;
    assign o_vtx.last_vertex = r_last;

endmodule

/* rtl/circle_vertex_generator.sv */
// ----------------------------------------------------------------------------
// Circle vertex generator
// Culls a circle against the view rectangle and emits its polygon vertices.
// ----------------------------------------------------------------------------
// A visible request produces TABLE_POINTS vertices, or half as many when the
// radius is below the small-radius limit, one per cycle unless the vertex side
// stalls, from an index sequencer that holds the request; a culled request
// produces one rejected transfer. The next request is taken in the cycle its
// predecessor issues its final vertex. Each vertex passes a three-stage
// pipeline (lookup, multiply, centre add), each stage registered.
// There is no start-up delay after reset.
module circle_vertex_generator
    import cvg_pkg::*;
#(
    parameter int TABLE_POINTS  = TABLE_POINTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cvg_req_if.sink               i_req,
    cvg_vtx_if.source             o_vtx
);

    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam logic [IDX_W-1:0] FULL_LAST = IDX_W'(TABLE_POINTS - 1);
    localparam logic [IDX_W-1:0] HALF_LAST = IDX_W'(TABLE_POINTS / 2 - 1);

    logic signed [COORD_W-1:0] r_view_left, r_view_top, r_view_right, r_view_bottom;
    logic [RADIUS_W-1:0]       r_small_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_left   <= '0;
            r_view_top    <= '0;
            r_view_right  <= '0;
            r_view_bottom <= '0;
            r_small_limit <= SMALL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VIEW_LEFT:   r_view_left   <= i_cfg_data;
                CFG_VIEW_TOP:    r_view_top    <= i_cfg_data;
                CFG_VIEW_RIGHT:  r_view_right  <= i_cfg_data;
                CFG_VIEW_BOTTOM: r_view_bottom <= i_cfg_data;
                CFG_SMALL_LIMIT: r_small_limit <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // Bounding-box test on the incoming request, all edges inclusive.
    logic signed [COORD_W:0] w_x_lo, w_x_hi, w_y_lo, w_y_hi;
    logic                    w_reject;

    always_comb begin
        w_x_lo   = $signed({i_req.center_x[COORD_W-1], i_req.center_x})
                 - $signed({5'b0, i_req.circle_radius});
        w_x_hi   = $signed({i_req.center_x[COORD_W-1], i_req.center_x})
                 + $signed({5'b0, i_req.circle_radius});
        w_y_lo   = $signed({i_req.center_y[COORD_W-1], i_req.center_y})
                 - $signed({5'b0, i_req.circle_radius});
        w_y_hi   = $signed({i_req.center_y[COORD_W-1], i_req.center_y})
                 + $signed({5'b0, i_req.circle_radius});
        w_reject = (w_x_lo > (COORD_W+1)'(r_view_right))
                || (w_x_hi < (COORD_W+1)'(r_view_left))
                || (w_y_lo > (COORD_W+1)'(r_view_bottom))
                || (w_y_hi < (COORD_W+1)'(r_view_top));
    end

    // Index sequencer.
    logic                      r_busy;
    logic                      r_reject;
    logic                      r_half;
    logic [IDX_W-1:0]          r_k;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [RADIUS_W-1:0]       r_radius;

    logic             w_issue_ready, w_issue_fire, w_issue_last, w_req_fire;
    logic [IDX_W-1:0] w_issue_idx;
    t_issue           w_issue;

    assign w_issue_last = r_reject || (r_half ? (r_k == HALF_LAST) : (r_k == FULL_LAST));
    assign w_issue_fire = r_busy && w_issue_ready;
    assign w_issue_idx  = r_half ? {r_k[IDX_W-2:0], 1'b0} : r_k;
    assign i_req.ready  = !r_busy || (w_issue_fire && w_issue_last);
    assign w_req_fire   = i_req.valid && i_req.ready;

    assign w_issue.cx     = r_cx;
    assign w_issue.cy     = r_cy;
    assign w_issue.radius = r_radius;
    assign w_issue.reject = r_reject;
    assign w_issue.last   = w_issue_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (w_req_fire) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (w_issue_fire) begin
            if (w_issue_last) begin
                r_busy <= 1'b0;
                r_k    <= '0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_cx     <= i_req.center_x;
            r_cy     <= i_req.center_y;
            r_radius <= i_req.circle_radius;
            r_reject <= w_reject;
            r_half   <= (i_req.circle_radius < r_small_limit);
        end
    end

    cvg_vertex_pipe #(
        .TABLE_POINTS  (TABLE_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_valid (r_busy),
        .o_issue_ready (w_issue_ready),
        .i_issue_idx   (w_issue_idx),
        .i_issue       (w_issue),
        .o_vtx         (o_vtx)
    );

    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.rejected) |-> o_vtx.last_vertex)
        else $error("rejected transfer without last_vertex");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.rejected) |-> (o_vtx.vertex_x == '0 && o_vtx.vertex_y == '0))
        else $error("rejected transfer carries a non-zero vertex");

    a_half_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_half) |-> (r_k <= HALF_LAST))
        else $error("halved vertex count overrun");

    a_issue_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> (r_busy && r_k == '0))
        else $error("accepted request not loaded into the sequencer");

endmodule

/* tb/circle_vertex_generator_tb.sv */
// ----------------------------------------------------------------------------
// Circle vertex generator testbench
// Sends circle requests over the valid/ready request channel and checks each
// vertex transfer against a predictor that builds its own sine/cosine table
// and culls against its own copy of the view registers. A short table of
// directed requests covers the edges of the view test, the small-radius
// switch and extreme fields; randomised requests over several register
// settings follow, with idle bursts and one long stall on the vertex side.
// ----------------------------------------------------------------------------
module circle_vertex_generator_tb
    import cvg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS          = TABLE_POINTS_DEF;
    localparam int FRAC            = FRACTION_BITS_DEF;
    localparam int SERIES_TERMS    = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_ITEMS     = 100;
    localparam int DIRECTED_ROWS   = 20;
    localparam int MAX_REPORTS     = 10;

    localparam longint unsigned Q30_UNIT    = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // No register lives at this index, so a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic signed [VERTEX_W-1:0] x;
        logic signed [VERTEX_W-1:0] y;
        logic                       rejected;
        logic                       last;
    } t_vertex;

    typedef struct {
        int left;
        int top;
        int right;
        int bottom;
        int limit;
    } t_view;

    typedef enum {CHECK_MODEL, CHECK_REJECT, CHECK_CENTRE} t_row_check;

    typedef struct {
        int         phase;
        int         cx;
        int         cy;
        int         r;
        t_row_check chk;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cvg_req_if req_ch ();
    cvg_vtx_if vtx_ch ();

    int      unit_sin [POINTS];
    int      unit_cos [POINTS];
    t_view   view_model;
    t_vertex pending_vertices [$];
    int      mismatches = 0;
    bit      calm;
    bit      hold_off_req;
    bit      hold_off_done;

    // Phase 0 runs on the reset values; phase 2 is an inverted rectangle.
    t_view directed_views [3] = '{
        '{0, 0, 0, 0, 20},
        '{-32768, -32768, 32767, 32767, 0},
        '{100, 50, -100, -50, 4095}
    };

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{0, 0, 0, 0, CHECK_CENTRE},
        '{0, 1, 0, 0, CHECK_REJECT},
        '{0, -1, 0, 0, CHECK_REJECT},
        '{0, 0, 1, 0, CHECK_REJECT},
        '{0, 0, -1, 0, CHECK_REJECT},
        '{0, 1, -1, 1, CHECK_MODEL},
        '{0, 0, 0, 4095, CHECK_MODEL},
        '{0, -32768, -32768, 4095, CHECK_REJECT},
        '{0, 32767, 32767, 4095, CHECK_REJECT},
        '{0, 20, 0, 20, CHECK_MODEL},
        '{0, 0, 19, 19, CHECK_MODEL},
        '{1, -32768, -32768, 4095, CHECK_MODEL},
        '{1, 32767, 32767, 4095, CHECK_MODEL},
        '{1, 32767, -32768, 0, CHECK_CENTRE},
        '{1, -32768, 32767, 1, CHECK_MODEL},
        '{2, 0, 0, 200, CHECK_MODEL},
        '{2, 0, 0, 50, CHECK_REJECT},
        '{2, 0, 0, 4095, CHECK_MODEL},
        '{2, 99, 0, 200, CHECK_MODEL},
        '{2, 101, 0, 200, CHECK_REJECT}
    };

    circle_vertex_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_vtx       (vtx_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sine and cosine of idx/POINTS of a turn in Q30, from a truncated series
    // on the angle folded into the first quadrant.
    function automatic void unit_circle_q30(input int unsigned idx,
                                            output longint s_q30, output longint c_q30);
        longint unsigned phase;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term_s;
        longint unsigned term_c;
        longint unsigned div_s;
        longint unsigned div_c;
        longint          sum_s;
        longint          sum_c;
        logic [1:0]      quadrant;
        phase    = {32'd0, idx};
        phase    = (phase << 32) / POINTS;
        quadrant = phase[31:30];
        ang      = ((phase & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
        ang2     = (ang * ang) >> 30;
        term_s   = ang;
        term_c   = Q30_UNIT;
        sum_s    = 0;
        sum_c    = 0;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            if (k % 2 == 1) begin
                sum_s = sum_s - longint'(term_s);
                sum_c = sum_c - longint'(term_c);
            end else begin
                sum_s = sum_s + longint'(term_s);
                sum_c = sum_c + longint'(term_c);
            end
            div_s  = (2 * k + 2) * (2 * k + 3);
            div_c  = (2 * k + 1) * (2 * k + 2);
            term_s = ((term_s * ang2) >> 30) / div_s;
            term_c = ((term_c * ang2) >> 30) / div_c;
        end
        if (sum_s < 0) sum_s = 0;
        if (sum_s > longint'(Q30_UNIT)) sum_s = longint'(Q30_UNIT);
        if (sum_c < 0) sum_c = 0;
        if (sum_c > longint'(Q30_UNIT)) sum_c = longint'(Q30_UNIT);
        case (quadrant)
            2'd0: begin
                s_q30 = sum_s;
                c_q30 = sum_c;
            end
            2'd1: begin
                s_q30 = sum_c;
                c_q30 = -sum_s;
            end
            2'd2: begin
                s_q30 = -sum_s;
                c_q30 = -sum_c;
            end
            default: begin
                s_q30 = -sum_c;
                c_q30 = sum_s;
            end
        endcase
    endfunction

    // Rounds by magnitude, half away from zero.
    function automatic int round_to_frac(longint v);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        return (v < 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int scale_by_radius(int r, int e);
        int mag;
        mag = (r * ((e < 0) ? -e : e)) >> FRAC;
        return (e < 0) ? -mag : mag;
    endfunction

    // Appends one expected vertex at the tail of the queue.
    function automatic void queue_vertex(t_vertex v);
        pending_vertices = {pending_vertices, v};
    endfunction

    function automatic void predict_vertices(int cx, int cy, int r);
        t_vertex v;
        int      stride;
        int      count;
        if (cx - r > view_model.right || cx + r < view_model.left ||
            cy - r > view_model.bottom || cy + r < view_model.top) begin
            v = '{x: '0, y: '0, rejected: 1'b1, last: 1'b1};
            queue_vertex(v);
            return;
        end
        stride = (r < view_model.limit) ? 2 : 1;
        count  = POINTS / stride;
        for (int k = 0; k < count; k++) begin
            v.x        = VERTEX_W'(cx + scale_by_radius(r, unit_sin[k * stride]));
            v.y        = VERTEX_W'(cy + scale_by_radius(r, unit_cos[k * stride]));
            v.rejected = 1'b0;
            v.last     = (k == count - 1);
            queue_vertex(v);
        end
    endfunction

    function automatic int pick_near(int a, int b, int r);
        int lo;
        int hi;
        lo = ((a < b) ? a : b) - r - 8;
        hi = ((a > b) ? a : b) + r + 8;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        if (lo > 32767) lo = 32767;
        if (hi < lo) hi = lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Mostly circles around the view rectangle, some anywhere on the plane.
    function automatic void draw_circle(output int cx, output int cy, output int r);
        case ($urandom_range(0, 3))
            0: r = $urandom_range(0, 40);
            1: r = view_model.limit - 2 + int'($urandom_range(0, 3));
            2: r = $urandom_range(0, 300);
            default: r = $urandom_range(0, 4095);
        endcase
        if (r < 0) r = 0;
        if (r > 4095) r = 4095;
        if ($urandom_range(0, 4) == 0) begin
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            cx = pick_near(view_model.left, view_model.right, r);
            cy = pick_near(view_model.top, view_model.bottom, r);
        end
    endfunction

    function automatic t_view random_view(int kind);
        t_view v;
        case (kind)
            0: begin
                v.left   = -int'($urandom_range(0, 3000));
                v.right  = v.left + int'($urandom_range(0, 6000));
                v.top    = -int'($urandom_range(0, 3000));
                v.bottom = v.top + int'($urandom_range(0, 6000));
                v.limit  = $urandom_range(0, 100);
            end
            1: begin
                v.left   = int'($urandom_range(0, 65535)) - 32768;
                v.right  = int'($urandom_range(0, 65535)) - 32768;
                v.top    = int'($urandom_range(0, 65535)) - 32768;
                v.bottom = int'($urandom_range(0, 65535)) - 32768;
                v.limit  = $urandom_range(0, 4095);
            end
            2: v = '{-32768, -32768, 32767, 32767, 0};
            default: begin
                v.left   = -int'($urandom_range(0, 1500));
                v.right  = v.left + int'($urandom_range(0, 3000));
                v.top    = -int'($urandom_range(0, 1500));
                v.bottom = v.top + int'($urandom_range(0, 3000));
                v.limit  = 20;
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        case (idx)
            CFG_VIEW_LEFT:   view_model.left   = int'($signed(data));
            CFG_VIEW_TOP:    view_model.top    = int'($signed(data));
            CFG_VIEW_RIGHT:  view_model.right  = int'($signed(data));
            CFG_VIEW_BOTTOM: view_model.bottom = int'($signed(data));
            CFG_SMALL_LIMIT: view_model.limit  = int'(data[RADIUS_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_view(t_view v);
        write_reg(CFG_VIEW_LEFT, CFG_DATA_W'(v.left));
        write_reg(CFG_VIEW_TOP, CFG_DATA_W'(v.top));
        write_reg(CFG_VIEW_RIGHT, CFG_DATA_W'(v.right));
        write_reg(CFG_VIEW_BOTTOM, CFG_DATA_W'(v.bottom));
        write_reg(CFG_SMALL_LIMIT, CFG_DATA_W'(v.limit));
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Lets every expected vertex arrive, then idles before returning.
    task automatic wait_drained();
        int guard;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        guard = 0;
        while (pending_vertices.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_circle(int cx, int cy, int r, t_row_check chk);
        t_vertex v;
        int      count;
        int      gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid         = 1'b1;
        req_ch.center_x      = COORD_W'(cx);
        req_ch.center_y      = COORD_W'(cy);
        req_ch.circle_radius = RADIUS_W'(r);
        do @(posedge i_clk); while (!req_ch.ready);
        case (chk)
            CHECK_REJECT: begin
                v = '{x: '0, y: '0, rejected: 1'b1, last: 1'b1};
                queue_vertex(v);
            end
            CHECK_CENTRE: begin
                // A zero radius puts every vertex on the centre itself.
                count = (r < view_model.limit) ? POINTS / 2 : POINTS;
                for (int k = 0; k < count; k++) begin
                    v = '{x: VERTEX_W'(cx), y: VERTEX_W'(cy), rejected: 1'b0,
                          last: (k == count - 1)};
                    queue_vertex(v);
                end
            end
            default: predict_vertices(cx, cy, r);
        endcase
    endtask

    // Vertex side: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        vtx_ch.ready  = 1'b0;
        hold_off_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                vtx_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 17);
                vtx_ch.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                vtx_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (i_rst_n && vtx_ch.valid && vtx_ch.ready) begin
            got = '{x: vtx_ch.vertex_x, y: vtx_ch.vertex_y, rejected: vtx_ch.rejected,
                    last: vtx_ch.last_vertex};
            if (pending_vertices.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected vertex transfer: x=%0d y=%0d rejected=%0b last=%0b",
                             got.x, got.y, got.rejected, got.last);
                mismatches++;
            end else begin
                want = pending_vertices.pop_front();
                if (got.x !== want.x || got.y !== want.y ||
                    got.rejected !== want.rejected || got.last !== want.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("vertex mismatch: expected x=%0d y=%0d rej=%0b last=%0b",
                                 want.x, want.y, want.rejected, want.last);
                        $display("                 got      x=%0d y=%0d rej=%0b last=%0b",
                                 got.x, got.y, got.rejected, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        longint s_q30;
        longint c_q30;
        int     cur_phase;
        int     cx;
        int     cy;
        int     r;
        int     missing;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.center_x      = '0;
        req_ch.center_y      = '0;
        req_ch.circle_radius = '0;
        calm                 = 1'b0;
        hold_off_req         = 1'b0;
        view_model           = directed_views[0];
        for (int i = 0; i < POINTS; i++) begin
            unit_circle_q30(i, s_q30, c_q30);
            unit_sin[i] = round_to_frac(s_q30);
            unit_cos[i] = round_to_frac(c_q30);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_phase = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].phase != cur_phase) begin
                cur_phase = directed_rows[i].phase;
                wait_drained();
                apply_view(directed_views[cur_phase]);
                if (cur_phase == 2) begin
                    write_reg(CFG_IDX_SPARE, 16'h5A5A);
                    @(negedge i_clk);
                    cfg_we = 1'b0;
                end
            end
            send_circle(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].r,
                        directed_rows[i].chk);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            // The closing phase runs with both sides streaming flat out.
            if (p == RANDOM_PHASES - 1) calm = 1'b1;
            apply_view(random_view(p));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 30) hold_off_req = 1'b1;
                draw_circle(cx, cy, r);
                send_circle(cx, cy, r, CHECK_MODEL);
            end
        end

        wait_drained();
        missing = pending_vertices.size();
        if (missing != 0) begin
            $display("%0d expected vertices never arrived", missing);
        end
        if (mismatches == 0 && missing == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cvg_pkg.sv
rtl/cvg_req_if.sv
rtl/cvg_vtx_if.sv
rtl/cvg_vertex_pipe.sv
rtl/circle_vertex_generator.sv
tb/circle_vertex_generator_tb.sv
